// File: src/keyframe_linear_sampler_unit_assert.svh
// Assertion macros used by the checker file (kfls_checker.sv).
`ifndef KEYFRAME_LINEAR_SAMPLER_UNIT_ASSERT_SVH
`define KEYFRAME_LINEAR_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KFLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/kfls_pkg.sv
package kfls_pkg;

  localparam int KFLS_MAX_KEYS = 64;

  localparam int TIME_W     = 32;
  localparam int COMP_W     = 32;
  localparam int NUM_COMP   = 3;
  localparam int VEC_W      = NUM_COMP * COMP_W;
  localparam int ENTRY_W    = TIME_W + VEC_W;
  localparam int IN_DATA_W  = TIME_W + VEC_W;
  localparam int OUT_DATA_W = VEC_W;
  localparam int CMD_W      = 2;
  localparam int STS_W      = 2;
  localparam int WGT_W      = 17;
  localparam int DIV_STEPS  = WGT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int COMP_IDX_W = $clog2(NUM_COMP);

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] kfls_vec_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CLEAR  = 2'd2
  } kfls_cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } kfls_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_RESP
  } kfls_state_t;

  typedef enum logic [1:0] {
    BL_IDLE,
    BL_SUB,
    BL_MUL,
    BL_ADD
  } kfls_bl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kfls_unit_sts_t;

endpackage

// File: src/kfls_ram.sv
module kfls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/kfls_div.sv
// Restoring divider, one quotient bit per cycle: quo = (diff << 16) / span.
// Expects diff <= span; span of zero gives zero.
module kfls_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [kfls_pkg::TIME_W-1:0]   diff,
  input  logic [kfls_pkg::TIME_W-1:0]   span,
  output kfls_pkg::kfls_unit_sts_t      sts,
  output logic [kfls_pkg::WGT_W-1:0]    quo
);

  import kfls_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_W:0]      rem_r;
  logic [TIME_W-1:0]    span_r;
  logic [WGT_W-1:0]     quo_r;

  logic                 ge;
  logic [TIME_W:0]      sub;
  logic [TIME_W-1:0]    rem_keep;

  always_comb begin
    ge       = (rem_r >= {1'b0, span_r});
    sub      = rem_r - {1'b0, span_r};
    rem_keep = ge ? sub[TIME_W-1:0] : rem_r[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
        busy_r <= (span != '0);
        done_r <= (span == '0);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      span_r <= span;
      rem_r  <= {1'b0, diff};
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_keep, 1'b0};
      quo_r <= {quo_r[WGT_W-2:0], ge};
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign quo = quo_r;

endmodule

// File: src/kfls_blend.sv
// Per component: a + floor((b - a) * w / 2^16), one shared multiplier.
module kfls_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  kfls_pkg::kfls_vec_t         a_vec,
  input  kfls_pkg::kfls_vec_t         b_vec,
  input  logic [kfls_pkg::WGT_W-1:0]  wgt,
  output kfls_pkg::kfls_unit_sts_t    sts,
  output kfls_pkg::kfls_vec_t         res_vec
);

  import kfls_pkg::*;

  localparam logic [COMP_IDX_W-1:0] COMP_LAST = COMP_IDX_W'(NUM_COMP - 1);

  kfls_bl_state_t          state_r, state_nxt;
  logic [COMP_IDX_W-1:0]   comp_r;
  logic                    done_r;

  kfls_vec_t               a_r, b_r, res_r;
  logic [WGT_W-1:0]        wgt_r;
  logic signed [COMP_W:0]  d_r;
  logic signed [COMP_W+WGT_W+1:0] p_r;

  logic ld_sub, ld_mul, ld_add, fin;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BL_IDLE: if (start) state_nxt = BL_SUB;
      BL_SUB:  state_nxt = BL_MUL;
      BL_MUL:  state_nxt = BL_ADD;
      BL_ADD:  state_nxt = (comp_r == COMP_LAST) ? BL_IDLE : BL_SUB;
      default: state_nxt = BL_IDLE;
    endcase
  end

  always_comb begin
    ld_sub = 1'b0;
    ld_mul = 1'b0;
    ld_add = 1'b0;
    fin    = 1'b0;
    case (state_r)
      BL_SUB:  ld_sub = 1'b1;
      BL_MUL:  ld_mul = 1'b1;
      BL_ADD: begin
        ld_add = 1'b1;
        fin    = (comp_r == COMP_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BL_IDLE;
      comp_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= fin;
      if (state_r == BL_IDLE && start) begin
        comp_r <= '0;
      end else if (ld_add) begin
        comp_r <= comp_r + COMP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BL_IDLE && start) begin
      a_r   <= a_vec;
      b_r   <= b_vec;
      wgt_r <= wgt;
    end
    if (ld_sub) begin
      d_r <= $signed({b_r[comp_r][COMP_W-1], b_r[comp_r]})
           - $signed({a_r[comp_r][COMP_W-1], a_r[comp_r]});
    end
    if (ld_mul) begin
      p_r <= d_r * $signed({1'b0, wgt_r});
    end
    if (ld_add) begin
      res_r[comp_r] <= a_r[comp_r] + p_r[COMP_W+15:16];
    end
  end

  assign sts     = '{busy: (state_r != BL_IDLE), done: done_r};
  assign res_vec = res_r;

endmodule

// File: src/keyframe_linear_sampler_unit.sv
// Channel | Ports          | Transaction
// --------+----------------+--------------------------------------------------
// input   | in_t*          | tuser: command; tdata: time_point, key_x/y/z
// output  | out_t*         | tuser: status;  tdata: out_x, out_y, out_z
//
// One command at a time; in_tready is high only while idle.
// The time a sample takes is set by the key scan through the key memory, the 17-step
// serial divider and the shared multiplier (subtract, multiply and add per component).
// A waiting result does not block the next command; it only holds back the next result.
// rst_n is synchronous; the key memory is not cleared, only the key count.
module keyframe_linear_sampler_unit #(
  parameter int MAX_KEYS = kfls_pkg::KFLS_MAX_KEYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kfls_pkg::CMD_W-1:0]       in_tuser,   // command
  input  logic [kfls_pkg::IN_DATA_W-1:0]   in_tdata,   // time_point, key_x, key_y, key_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kfls_pkg::STS_W-1:0]       out_tuser,  // status
  output logic [kfls_pkg::OUT_DATA_W-1:0]  out_tdata   // out_x, out_y, out_z
);

  import kfls_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = $clog2(MAX_KEYS);

  kfls_state_t       state_r, state_nxt;
  kfls_cmd_t         cmd_r;
  logic [TIME_W-1:0] tp_r;
  kfls_vec_t         key_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     rd_idx_r;
  logic [CW-1:0]     chk_idx_r;
  logic              rv_r;
  logic [TIME_W-1:0] prev_t_r;
  kfls_vec_t         prev_v_r;
  kfls_vec_t         b_r;
  kfls_sts_t         res_sts_r;
  kfls_vec_t         res_r;
  logic              out_valid_r;
  kfls_sts_t         out_sts_r;
  kfls_vec_t         out_data_r;

  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  ent_t;
  kfls_vec_t          ent_v;
  logic               full, first_hit, match, last_hit, out_free;

  logic               ram_we, ram_re, div_start, blend_start, out_load, accept;

  kfls_unit_sts_t     div_sts, blend_sts;
  logic [WGT_W-1:0]   wgt;
  kfls_vec_t          blend_res;

  assign ent_t = ram_rdata[TIME_W-1:0];
  assign ent_v = ram_rdata[ENTRY_W-1:TIME_W];

  always_comb begin
    full      = (count_r == CW'(MAX_KEYS));
    out_free  = !out_valid_r || out_tready;
    first_hit = rv_r && (chk_idx_r == '0) && ((count_r == CW'(1)) || (tp_r <= ent_t));
    match     = rv_r && (chk_idx_r != '0) && (prev_t_r <= tp_r) && (tp_r <= ent_t);
    last_hit  = rv_r && (chk_idx_r != '0) && !match && (chk_idx_r == count_r - CW'(1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd_r == CMD_SAMPLE && count_r != '0) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (first_hit || last_hit) begin
          state_nxt = ST_RESP;
        end else if (match) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_sts.done) state_nxt = ST_BLEND;
      ST_BLEND: if (blend_sts.done) state_nxt = ST_RESP;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    blend_start = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_EXEC:  ram_we = (cmd_r == CMD_APPEND) && !full;
      ST_SCAN: begin
        ram_re    = (rd_idx_r < count_r);
        div_start = match;
      end
      ST_DIV:   blend_start = div_sts.done;
      ST_RESP:  out_load = out_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  kfls_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata ({key_r, tp_r}),
    .re    (ram_re),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  kfls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .diff  (tp_r - prev_t_r),
    .span  (ent_t - prev_t_r),
    .sts   (div_sts),
    .quo   (wgt)
  );

  kfls_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (blend_start),
    .a_vec   (prev_v_r),
    .b_vec   (b_r),
    .wgt     (wgt),
    .sts     (blend_sts),
    .res_vec (blend_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        rd_idx_r <= '0;
        rv_r     <= 1'b0;
        if (ram_we) begin
          count_r <= count_r + CW'(1);
        end else if (cmd_r == CMD_CLEAR) begin
          count_r <= '0;
        end
      end else if (state_r == ST_SCAN) begin
        rv_r      <= ram_re;
        chk_idx_r <= rd_idx_r;
        if (ram_re) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= kfls_cmd_t'(in_tuser);
      tp_r  <= in_tdata[TIME_W-1:0];
      key_r <= in_tdata[IN_DATA_W-1:TIME_W];
    end
    if (state_r == ST_EXEC) begin
      res_r <= '0;
      if (cmd_r == CMD_APPEND && full) begin
        res_sts_r <= STS_FULL;
      end else if (cmd_r == CMD_SAMPLE && count_r == '0) begin
        res_sts_r <= STS_EMPTY;
      end else begin
        res_sts_r <= STS_OK;
      end
    end
    if (state_r == ST_SCAN && rv_r) begin
      if (first_hit || last_hit) begin
        res_r <= ent_v;
      end else if (match) begin
        b_r <= ent_v;
      end else begin
        prev_t_r <= ent_t;
        prev_v_r <= ent_v;
      end
    end
    if (state_r == ST_BLEND && blend_sts.done) begin
      res_r <= blend_res;
    end
    if (out_load) begin
      out_sts_r  <= res_sts_r;
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/kfls_checker.sv
module kfls_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [kfls_pkg::CMD_W-1:0]       in_tuser,
  input logic [kfls_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [kfls_pkg::STS_W-1:0]       out_tuser,
  input logic [kfls_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import kfls_pkg::*;

`include "keyframe_linear_sampler_unit_assert.svh"

  logic in_acc;
  logic unused_in;

  assign in_acc    = in_tvalid && in_tready;
  assign unused_in = ^{in_tuser, in_tdata};

  `KFLS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `KFLS_ASSERT_NOW(a_err_zero, out_tvalid && (out_tuser != STS_OK), out_tdata == '0 || unused_in === 1'bx, "failed transaction carries data")
  `KFLS_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_tready, "second transaction taken while busy")
  `KFLS_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(out_tvalid), "result in cycle after transaction")

endmodule

bind keyframe_linear_sampler_unit kfls_checker u_kfls_checker (.*);

// File: dv/tb_top.sv
module tb_top;
  import kfls_pkg::*;

  localparam int          MAX_KEYS = KFLS_MAX_KEYS;
  localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN    = 32'h8000_0000;
  localparam logic [31:0] T_MAX    = 32'hFFFF_FFFF;
  localparam int          SETTLE   = 200;

  typedef struct packed {
    kfls_sts_t status;
    kfls_vec_t vec;
  } sample_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser   = '0;  // command
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // time_point, key_x, key_y, key_z
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [STS_W-1:0]      out_tuser;        // status
  logic [OUT_DATA_W-1:0] out_tdata;        // out_x, out_y, out_z

  logic [31:0]    key_time_tab [MAX_KEYS];
  kfls_vec_t      key_vec_tab  [MAX_KEYS];
  int             key_total     = 0;
  sample_result_t pending_results[$];
  sample_result_t seen_exp;
  kfls_vec_t      seen_vec;
  int             fail_count    = 0;
  int             items_sent    = 0;
  int             snd_idle_pct  = 0;
  int             rcv_stall_pct = 0;
  int             hold_left     = 0;

  keyframe_linear_sampler_unit #(.MAX_KEYS(MAX_KEYS)) u_top (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] blend_component(logic [31:0] a, logic [31:0] b,
                                                  logic [16:0] w);
    longint d;
    longint p;
    d = longint'($signed(b)) - longint'($signed(a));
    p = d * longint'(w);
    return 32'(longint'($signed(a)) + (p >>> 16));
  endfunction

  function automatic sample_result_t apply_command(kfls_cmd_t cmd, logic [31:0] t_pt,
                                                   kfls_vec_t kv);
    sample_result_t r;
    logic [31:0]    t0;
    logic [31:0]    t1;
    logic [63:0]    num;
    logic [16:0]    w;
    bit             hit;
    r   = '{status: STS_OK, vec: '0};
    hit = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (key_total >= MAX_KEYS) begin
          r.status = STS_FULL;
        end else begin
          key_time_tab[key_total] = t_pt;
          key_vec_tab[key_total]  = kv;
          key_total++;
        end
      end
      CMD_CLEAR: key_total = 0;
      CMD_SAMPLE: begin
        if (key_total == 0) begin
          r.status = STS_EMPTY;
        end else if (key_total == 1 || t_pt <= key_time_tab[0]) begin
          r.vec = key_vec_tab[0];
        end else begin
          for (int i = 0; i + 1 < key_total && !hit; i++) begin
            t0 = key_time_tab[i];
            t1 = key_time_tab[i+1];
            if (t0 <= t_pt && t_pt <= t1) begin
              hit = 1'b1;
              w   = '0;
              if (t1 != t0) begin
                num = {16'd0, t_pt - t0, 16'd0};
                w   = 17'(num / {32'd0, t1 - t0});
              end
              for (int c = 0; c < NUM_COMP; c++)
                r.vec[c] = blend_component(key_vec_tab[i][c], key_vec_tab[i+1][c], w);
            end
          end
          if (!hit) r.vec = key_vec_tab[key_total-1];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_component();
    case ($urandom_range(9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3, 4:    return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] next_key_time(logic [31:0] prev);
    logic [32:0] s;
    case ($urandom_range(7))
      0, 1:    s = {1'b0, prev};
      2, 3, 4: s = prev + $urandom_range(1, 'h100);
      5, 6:    s = prev + $urandom_range(1, 'h2_0000);
      default: s = prev + ($urandom >> 4);
    endcase
    return s[32] ? T_MAX : s[31:0];
  endfunction

  function automatic logic [31:0] pick_sample_time();
    int          idx;
    logic [31:0] t0;
    logic [31:0] last;
    logic [63:0] rnd;
    if (key_total == 0) return $urandom;
    idx  = $urandom_range(0, key_total - 1);
    t0   = key_time_tab[idx];
    last = key_time_tab[key_total-1];
    rnd  = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return t0;
      1: begin
        if (idx + 1 < key_total && key_time_tab[idx+1] >= t0)
          return t0 + 32'(rnd % ({32'd0, key_time_tab[idx+1] - t0} + 64'd1));
        return t0;
      end
      2: return (key_time_tab[0] == 0) ? 32'd0 : 32'(rnd % {32'd0, key_time_tab[0]});
      3: return (last > 32'hFFFF_0000) ? T_MAX : last + $urandom_range(1, 'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic send_item(kfls_cmd_t cmd, logic [31:0] t_pt, logic [31:0] kx,
                           logic [31:0] ky, logic [31:0] kz);
    sample_result_t exp_item;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {kz, ky, kx, t_pt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_item        = apply_command(cmd, t_pt, {kz, ky, kx});
    pending_results = {pending_results, exp_item};
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transaction status %0d data %h", $time, out_tuser,
                 out_tdata);
        fail_count++;
      end else begin
        seen_exp = pending_results.pop_front();
        seen_vec = out_tdata;
        check_field("status", 32'(seen_exp.status), 32'(out_tuser));
        check_field("out_x", seen_exp.vec[0], seen_vec[0]);
        check_field("out_y", seen_exp.vec[1], seen_vec[1]);
        check_field("out_z", seen_exp.vec[2], seen_vec[2]);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic test_empty_curve();
    send_item(CMD_SAMPLE, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_SAMPLE, T_MAX, '0, '0, '0);
  endtask

  task automatic test_single_key();
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_APPEND, 32'h0005_0000, Q_MAX, Q_MIN, '0);
    send_item(CMD_SAMPLE, '0, '0, '0, '0);
    send_item(CMD_SAMPLE, T_MAX, '0, '0, '0);
  endtask

  task automatic test_extreme_span();
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_APPEND, '0, Q_MIN, Q_MAX, T_MAX);
    send_item(CMD_APPEND, T_MAX, Q_MAX, Q_MIN, 32'd1);
    send_item(CMD_SAMPLE, 32'h8000_0000, '0, '0, '0);
    send_item(CMD_SAMPLE, T_MAX - 1, '0, '0, '0);
    send_item(CMD_SAMPLE, 32'd1, '0, '0, '0);
  endtask

  task automatic test_repeated_times();
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_APPEND, 32'h0032_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_item(CMD_APPEND, 32'h0064_0000, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_8000);
    send_item(CMD_APPEND, 32'h0064_0000, Q_MIN, Q_MAX, '0);
    send_item(CMD_SAMPLE, 32'h0064_0000, '0, '0, '0);
    send_item(CMD_SAMPLE, 32'h004B_0000, '0, '0, '0);
  endtask

  task automatic test_unordered_keys();
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_APPEND, 32'd300, 32'd1000, 32'd2000, 32'd3000);
    send_item(CMD_APPEND, 32'd100, 32'hFFFF_FC18, 32'd7, 32'd0);
    send_item(CMD_APPEND, 32'd200, 32'd5000, 32'hFFFF_FFF9, Q_MAX);
    send_item(CMD_SAMPLE, 32'd150, '0, '0, '0);
    send_item(CMD_SAMPLE, 32'd400, '0, '0, '0);
  endtask

  // mostly whole curves followed by samples, some loose noise
  task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
    int          goal;
    int          n_keys;
    int          n_samp;
    logic [31:0] t_acc;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    goal          = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(9) < 8) send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        n_keys = ($urandom_range(19) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 12);
        t_acc  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 'h10_0000);
        for (int k = 0; k < n_keys; k++) begin
          send_item(CMD_APPEND, t_acc, rand_component(), rand_component(), rand_component());
          t_acc = next_key_time(t_acc);
        end
        n_samp = $urandom_range(1, 8);
        for (int k = 0; k < n_samp; k++)
          send_item(CMD_SAMPLE, pick_sample_time(), $urandom, $urandom, $urandom);
      end else begin
        send_item(kfls_cmd_t'($urandom_range(2)), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_output_hold_off();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 600;
    repeat (16) begin
      if ($urandom_range(1) == 0)
        send_item(CMD_SAMPLE, pick_sample_time(), $urandom, $urandom, $urandom);
      else
        send_item(CMD_APPEND, $urandom, rand_component(), rand_component(), rand_component());
    end
  endtask

  task automatic test_sender_pause();
    snd_idle_pct  = 12;
    rcv_stall_pct = 12;
    repeat (10) send_item(kfls_cmd_t'($urandom_range(2)), pick_sample_time(), $urandom,
                          $urandom, $urandom);
    drain_results();
    repeat (10) send_item(CMD_SAMPLE, pick_sample_time(), $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_curve();
    test_single_key();
    test_extreme_span();
    test_repeated_times();
    test_unordered_keys();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 83, 0);
    test_random_traffic(300, 0, 83);
    test_random_traffic(300, 12, 12);
    test_output_hold_off();
    test_sender_pause();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("PASS keyframe_linear_sampler_unit");
    else
      $display("FAIL keyframe_linear_sampler_unit");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL keyframe_linear_sampler_unit");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/kfls_pkg.sv
src/kfls_ram.sv
src/kfls_div.sv
src/kfls_blend.sv
src/keyframe_linear_sampler_unit.sv
src/kfls_checker.sv
dv/tb_top.sv
